[rtl/dbdq_pkg.sv]
// ----------------------------------------------------------------------------
// dbdq_pkg
// Shared widths, register indexes, control word layout and the control store
// of the deadbeat d/q current controller.
// ----------------------------------------------------------------------------
package dbdq_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned UREG_W        = 31;
  localparam int unsigned CFG_IDX_W     = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PROD_W        = 2 * DATA_W;
  localparam int unsigned NUM_STEPS     = 19;
  localparam int unsigned STEP_W        = $clog2(NUM_STEPS);

  localparam logic [UREG_W-1:0] PERIOD_RST = UREG_W'(7);

  localparam logic [CFG_IDX_W-1:0] REG_DECAY     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TC_OVER_L = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_FLUX_TERM = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_L_OVER_TC = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_RMG       = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_IND       = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_PSI       = CFG_IDX_W'(7);

  typedef enum logic [3:0] {
    A_TC, A_WE, A_DECAY, A_TW, A_TCL, A_FLUX, A_LTC, A_RMG, A_LW, A_PSI
  } a_sel_e;

  typedef enum logic [3:0] {
    B_WE, B_IND, B_ID, B_IQ, B_LVD, B_LVQ, B_IDR, B_IQR, B_IPD, B_IPQ
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_NOP, ACC_LOAD, ACC_ADD, ACC_SUB
  } acc_op_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_TW, DST_LW, DST_IPD, DST_IPQ, DST_UD, DST_UQ
  } dst_e;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT
  } seq_e;

  typedef struct packed {
    a_sel_e  a_sel;
    b_sel_e  b_sel;
    acc_op_e acc_op;
    dst_e    dst;
    seq_e    seq;
  } ucode_t;

  // multiply issues in a step, the accumulator takes that product one step
  // later, and a store saturates the accumulator before that step's update
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    case (step)
      STEP_W'(0):  w = '{A_TC,    B_WE,  ACC_NOP,  DST_NONE, SEQ_WAIT_IN};
      STEP_W'(1):  w = '{A_TC,    B_WE,  ACC_NOP,  DST_NONE, SEQ_NEXT};
      STEP_W'(2):  w = '{A_WE,    B_IND, ACC_LOAD, DST_NONE, SEQ_NEXT};
      STEP_W'(3):  w = '{A_DECAY, B_ID,  ACC_LOAD, DST_TW,   SEQ_NEXT};
      STEP_W'(4):  w = '{A_TW,    B_IQ,  ACC_LOAD, DST_LW,   SEQ_NEXT};
      STEP_W'(5):  w = '{A_TCL,   B_LVD, ACC_ADD,  DST_NONE, SEQ_NEXT};
      STEP_W'(6):  w = '{A_DECAY, B_IQ,  ACC_ADD,  DST_NONE, SEQ_NEXT};
      STEP_W'(7):  w = '{A_TW,    B_ID,  ACC_LOAD, DST_IPD,  SEQ_NEXT};
      STEP_W'(8):  w = '{A_TCL,   B_LVQ, ACC_SUB,  DST_NONE, SEQ_NEXT};
      STEP_W'(9):  w = '{A_FLUX,  B_WE,  ACC_ADD,  DST_NONE, SEQ_NEXT};
      STEP_W'(10): w = '{A_LTC,   B_IDR, ACC_SUB,  DST_NONE, SEQ_NEXT};
      STEP_W'(11): w = '{A_RMG,   B_IPD, ACC_LOAD, DST_IPQ,  SEQ_NEXT};
      STEP_W'(12): w = '{A_LW,    B_IPQ, ACC_ADD,  DST_NONE, SEQ_NEXT};
      STEP_W'(13): w = '{A_LTC,   B_IQR, ACC_SUB,  DST_NONE, SEQ_NEXT};
      STEP_W'(14): w = '{A_RMG,   B_IPQ, ACC_LOAD, DST_UD,   SEQ_NEXT};
      STEP_W'(15): w = '{A_LW,    B_IPD, ACC_ADD,  DST_NONE, SEQ_NEXT};
      STEP_W'(16): w = '{A_PSI,   B_WE,  ACC_ADD,  DST_NONE, SEQ_NEXT};
      STEP_W'(17): w = '{A_TC,    B_WE,  ACC_ADD,  DST_NONE, SEQ_NEXT};
      STEP_W'(18): w = '{A_TC,    B_WE,  ACC_NOP,  DST_UQ,   SEQ_WAIT_OUT};
      default:     w = '{A_TC,    B_WE,  ACC_NOP,  DST_NONE, SEQ_WAIT_OUT};
    endcase
    return w;
  endfunction

endpackage

[rtl/dbdq_meas_if.sv]
// ----------------------------------------------------------------------------
// dbdq_meas_if
// Request channel carrying measured currents, speed and current references.
// ----------------------------------------------------------------------------
interface dbdq_meas_if;
  import dbdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] meas_d_current;
  logic signed [DATA_W-1:0] meas_q_current;
  logic signed [DATA_W-1:0] elec_speed;
  logic signed [DATA_W-1:0] target_d_current;
  logic signed [DATA_W-1:0] target_q_current;

  modport source (
    output valid, meas_d_current, meas_q_current, elec_speed,
           target_d_current, target_q_current,
    input  ready
  );

  modport sink (
    input  valid, meas_d_current, meas_q_current, elec_speed,
           target_d_current, target_q_current,
    output ready
  );
endinterface

[rtl/dbdq_volt_if.sv]
// ----------------------------------------------------------------------------
// dbdq_volt_if
// Request channel carrying the saturated d/q voltage commands.
// ----------------------------------------------------------------------------
interface dbdq_volt_if;
  import dbdq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] volt_d;
  logic signed [DATA_W-1:0] volt_q;

  modport source (
    output valid, volt_d, volt_q,
    input  ready
  );

  modport sink (
    input  valid, volt_d, volt_q,
    output ready
  );
endinterface

[rtl/deadbeat_dq_current_controller_unit.sv]
// the voltage request is raised at the last step of the 19-step control
//   program; a new request is taken only once that program has run, since
//   all steps share a single registered 32x32 multiplier and one accumulator
// a finished result waits in the output register while the next request runs
// reset: asynchronous, active low; coefficients to their defaults, stored
//   voltages to zero, no clearing pass
// ----------------------------------------------------------------------------
// deadbeat_dq_current_controller_unit
// Deadbeat predictive d/q current controller: microcoded sequencer over one
// shared multiplier, a saturating accumulator and a small register file.
// ----------------------------------------------------------------------------
module deadbeat_dq_current_controller_unit #(
  parameter int unsigned FRAC_BITS = dbdq_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dbdq_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dbdq_pkg::DATA_W-1:0]    cfg_data_i,
  dbdq_meas_if.sink                      meas_i,
  dbdq_volt_if.source                    volt_o
);
  import dbdq_pkg::*;

  localparam int unsigned PS_W    = PROD_W - FRAC_BITS;
  localparam int unsigned ACC_EXT = 3;
  localparam int unsigned ACC_W   = PS_W + ACC_EXT;
  localparam logic [DATA_W-1:0] DECAY_RST = DATA_W'(1) << FRAC_BITS;

  logic signed [DATA_W-1:0] decay_q, rmg_q;
  logic [UREG_W-1:0]        tc_q, tcl_q, flux_q, ltc_q, ind_q, psi_q;

  logic signed [DATA_W-1:0] id_q, iq_q, we_q, idr_q, iqr_q;
  logic signed [DATA_W-1:0] tw_q, lw_q, ipd_q, ipq_q;
  logic signed [DATA_W-1:0] lvd_q, lvq_q;
  logic signed [DATA_W-1:0] out_d_q, out_q_q;
  logic                     out_valid_q, out_valid_d;

  logic [STEP_W-1:0]        step_q, step_d;
  ucode_t                   uw;
  logic                     stall, run;

  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PS_W-1:0]   prod_sh;
  logic signed [ACC_W-1:0]  prod_ext, acc_q, acc_d;
  logic signed [DATA_W-1:0] acc_sat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RST;
      tc_q    <= PERIOD_RST;
      tcl_q   <= '0;
      flux_q  <= '0;
      ltc_q   <= '0;
      rmg_q   <= '0;
      ind_q   <= '0;
      psi_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DECAY:     decay_q <= cfg_data_i;
        REG_PERIOD:    tc_q    <= cfg_data_i[UREG_W-1:0];
        REG_TC_OVER_L: tcl_q   <= cfg_data_i[UREG_W-1:0];
        REG_FLUX_TERM: flux_q  <= cfg_data_i[UREG_W-1:0];
        REG_L_OVER_TC: ltc_q   <= cfg_data_i[UREG_W-1:0];
        REG_RMG:       rmg_q   <= cfg_data_i;
        REG_IND:       ind_q   <= cfg_data_i[UREG_W-1:0];
        REG_PSI:       psi_q   <= cfg_data_i[UREG_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  assign uw = ucode_rom(step_q);

  always_comb begin
    case (uw.seq)
      SEQ_WAIT_IN:  stall = !meas_i.valid;
      SEQ_WAIT_OUT: stall = out_valid_q && !volt_o.ready;
      default:      stall = 1'b0;
    endcase
    run = !stall;
  end

  always_comb begin
    step_d = step_q;
    if (run) begin
      if (uw.seq == SEQ_WAIT_OUT) begin
        step_d = '0;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  assign meas_i.ready = (uw.seq == SEQ_WAIT_IN);

  always_ff @(posedge clk_i) begin
    if (meas_i.valid && meas_i.ready) begin
      id_q  <= meas_i.meas_d_current;
      iq_q  <= meas_i.meas_q_current;
      we_q  <= meas_i.elec_speed;
      idr_q <= meas_i.target_d_current;
      iqr_q <= meas_i.target_q_current;
    end
  end

  // shared multiplier
  always_comb begin
    case (uw.a_sel)
      A_TC:    op_a = {1'b0, tc_q};
      A_WE:    op_a = we_q;
      A_DECAY: op_a = decay_q;
      A_TW:    op_a = tw_q;
      A_TCL:   op_a = {1'b0, tcl_q};
      A_FLUX:  op_a = {1'b0, flux_q};
      A_LTC:   op_a = {1'b0, ltc_q};
      A_RMG:   op_a = rmg_q;
      A_LW:    op_a = lw_q;
      A_PSI:   op_a = {1'b0, psi_q};
      default: op_a = '0;
    endcase
    case (uw.b_sel)
      B_WE:    op_b = we_q;
      B_IND:   op_b = {1'b0, ind_q};
      B_ID:    op_b = id_q;
      B_IQ:    op_b = iq_q;
      B_LVD:   op_b = lvd_q;
      B_LVQ:   op_b = lvq_q;
      B_IDR:   op_b = idr_q;
      B_IQR:   op_b = iqr_q;
      B_IPD:   op_b = ipd_q;
      B_IPQ:   op_b = ipq_q;
      default: op_b = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
  end

  // floor shift by taking the upper bits
  assign prod_sh  = $signed(prod_q[PROD_W-1:FRAC_BITS]);
  assign prod_ext = {{ACC_EXT{prod_sh[PS_W-1]}}, prod_sh};

  always_comb begin
    case (uw.acc_op)
      ACC_LOAD: acc_d = prod_ext;
      ACC_ADD:  acc_d = acc_q + prod_ext;
      ACC_SUB:  acc_d = acc_q - prod_ext;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      acc_q <= acc_d;
    end
  end

  // saturation to 32-bit signed
  always_comb begin
    if (acc_q[ACC_W-1:DATA_W-1] == '0 || acc_q[ACC_W-1:DATA_W-1] == '1) begin
      acc_sat = acc_q[DATA_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      acc_sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      acc_sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (run) begin
      case (uw.dst)
        DST_TW:  tw_q  <= acc_sat;
        DST_LW:  lw_q  <= acc_sat;
        DST_IPD: ipd_q <= acc_sat;
        DST_IPQ: ipq_q <= acc_sat;
        DST_UQ: begin
          out_d_q <= lvd_q;
          out_q_q <= acc_sat;
        end
        default: ;
      endcase
    end
  end

  // stored voltages of the previous period
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvd_q <= '0;
      lvq_q <= '0;
    end else if (run) begin
      if (uw.dst == DST_UD) begin
        lvd_q <= acc_sat;
      end
      if (uw.dst == DST_UQ) begin
        lvq_q <= acc_sat;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (volt_o.valid && volt_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (run && uw.dst == DST_UQ) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign volt_o.valid  = out_valid_q;
  assign volt_o.volt_d = out_d_q;
  assign volt_o.volt_q = out_q_q;

endmodule

[rtl/dbdq_checker.sv]
// ----------------------------------------------------------------------------
// dbdq_checker
// Port-level checks on the deadbeat d/q current controller, bound to the top.
// ----------------------------------------------------------------------------
module dbdq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [2*dbdq_pkg::DATA_W-1:0]   out_data_i
);
  import dbdq_pkg::*;

  // result request held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("voltage request dropped before accept");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("voltage payload changed while stalled");

  // one request in flight at a time
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second request taken while busy");

  // no result appears straight after an accept
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result raised too early");

endmodule

bind deadbeat_dq_current_controller_unit dbdq_checker u_dbdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (meas_i.valid),
  .in_ready_i  (meas_i.ready),
  .out_valid_i (volt_o.valid),
  .out_ready_i (volt_o.ready),
  .out_data_i  ({volt_o.volt_d, volt_o.volt_q})
);

[sim/dbdq_tb_pkg.sv]
// ----------------------------------------------------------------------------
// dbdq_tb_pkg
// Request and voltage types for the controller testbench, and a scoreboard
// that predicts each d/q voltage command from its own copy of the
// coefficients and the held voltages, then checks the results in order.
// ----------------------------------------------------------------------------
package dbdq_tb_pkg;
  import dbdq_pkg::*;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t  W_MAX    = 32'sh7FFF_FFFF;
  localparam word_t  W_MIN    = 32'sh8000_0000;
  localparam longint WORD_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint WORD_MIN = -(longint'(1) <<< (DATA_W - 1));

  typedef struct packed {
    word_t id;
    word_t iq;
    word_t we;
    word_t idr;
    word_t iqr;
  } meas_req_t;

  typedef struct packed {
    word_t vd;
    word_t vq;
  } volt_pair_t;

  typedef struct packed {
    logic [DATA_W-1:0] decay;
    logic [DATA_W-1:0] period;
    logic [DATA_W-1:0] tc_over_l;
    logic [DATA_W-1:0] flux_term;
    logic [DATA_W-1:0] l_over_tc;
    logic [DATA_W-1:0] rmg;
    logic [DATA_W-1:0] ind;
    logic [DATA_W-1:0] psi;
  } coeff_set_t;

  typedef enum logic [1:0] {
    STYLE_TYPICAL, STYLE_WIDE, STYLE_MAX, STYLE_MIN
  } coeff_style_e;

  class volt_command_scoreboard;
    word_t             decay_coeff;
    logic [UREG_W-1:0] period;
    logic [UREG_W-1:0] period_over_ind;
    logic [UREG_W-1:0] flux_term_coeff;
    logic [UREG_W-1:0] ind_over_period;
    word_t             resist_minus_gain;
    logic [UREG_W-1:0] inductance;
    logic [UREG_W-1:0] flux_linkage;
    word_t             held_volt_d;
    word_t             held_volt_q;
    volt_pair_t        expected_volts[$];
    int unsigned       frac_bits;
    int unsigned       n_results;
    int unsigned       n_mismatch;
    int unsigned       n_clamped;

    function new(int unsigned frac);
      frac_bits         = frac;
      decay_coeff       = word_t'(longint'(1) <<< frac);
      period            = PERIOD_RST;
      period_over_ind   = '0;
      flux_term_coeff   = '0;
      ind_over_period   = '0;
      resist_minus_gain = '0;
      inductance        = '0;
      flux_linkage      = '0;
      held_volt_d       = '0;
      held_volt_q       = '0;
      n_results         = 0;
      n_mismatch        = 0;
      n_clamped         = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_DECAY:     decay_coeff       = word_t'(data);
        REG_PERIOD:    period            = data[UREG_W-1:0];
        REG_TC_OVER_L: period_over_ind   = data[UREG_W-1:0];
        REG_FLUX_TERM: flux_term_coeff   = data[UREG_W-1:0];
        REG_L_OVER_TC: ind_over_period   = data[UREG_W-1:0];
        REG_RMG:       resist_minus_gain = word_t'(data);
        REG_IND:       inductance        = data[UREG_W-1:0];
        REG_PSI:       flux_linkage      = data[UREG_W-1:0];
        default: ;
      endcase
    endfunction

    // exact product, floor shift
    function longint qmul(longint a, longint b);
      return (a * b) >>> frac_bits;
    endfunction

    function longint clamp(longint x);
      if (x > WORD_MAX) return WORD_MAX;
      if (x < WORD_MIN) return WORD_MIN;
      return x;
    endfunction

    function void note_request(meas_req_t r);
      longint     spd_tc;
      longint     spd_l;
      longint     id_next;
      longint     iq_next;
      longint     vd;
      longint     vq;
      volt_pair_t e;
      spd_tc  = clamp(qmul(longint'(period), longint'(r.we)));
      id_next = clamp(qmul(longint'(decay_coeff), longint'(r.id))
                      + qmul(spd_tc, longint'(r.iq))
                      + qmul(longint'(period_over_ind), longint'(held_volt_d)));
      iq_next = clamp(qmul(longint'(decay_coeff), longint'(r.iq))
                      - qmul(spd_tc, longint'(r.id))
                      + qmul(longint'(period_over_ind), longint'(held_volt_q))
                      - qmul(longint'(flux_term_coeff), longint'(r.we)));
      spd_l   = clamp(qmul(longint'(r.we), longint'(inductance)));
      vd = clamp(qmul(longint'(ind_over_period), longint'(r.idr))
                 + qmul(longint'(resist_minus_gain), id_next)
                 - qmul(spd_l, iq_next));
      vq = clamp(qmul(longint'(ind_over_period), longint'(r.iqr))
                 + qmul(longint'(resist_minus_gain), iq_next)
                 + qmul(spd_l, id_next)
                 + qmul(longint'(flux_linkage), longint'(r.we)));
      held_volt_d = word_t'(vd);
      held_volt_q = word_t'(vq);
      e.vd = held_volt_d;
      e.vq = held_volt_q;
      expected_volts.push_back(e);
    endfunction

    function void flag(string msg);
      n_mismatch++;
      if (n_mismatch <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void check_volts(word_t vd, word_t vq);
      volt_pair_t e;
      n_results++;
      if (expected_volts.size() == 0) begin
        flag($sformatf("unexpected result volt_d=%0d volt_q=%0d", vd, vq));
        return;
      end
      e = expected_volts.pop_front();
      if (e.vd inside {W_MAX, W_MIN} || e.vq inside {W_MAX, W_MIN}) n_clamped++;
      if (vd !== e.vd) flag($sformatf("volt_d expected %0d got %0d", e.vd, vd));
      if (vq !== e.vq) flag($sformatf("volt_q expected %0d got %0d", e.vq, vq));
    endfunction

    function int unsigned pending();
      return expected_volts.size();
    endfunction
  endclass

endpackage

[sim/tb_deadbeat_dq_current_controller_unit.sv]
// ----------------------------------------------------------------------------
// tb_deadbeat_dq_current_controller_unit
// Drives measurement requests through the controller under directed corner
// values and randomised coefficient sets, with random idling on both sides
// and long output back-pressure, and checks every voltage command against
// the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_deadbeat_dq_current_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dbdq_pkg::*;
  import dbdq_tb_pkg::*;

  localparam int unsigned LATENCY      = 19;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SEG_ITEMS    = 192;
  localparam int unsigned NUM_SEGS     = 8;
  localparam int unsigned FRAC_ONE     = 1 << FRAC_BITS_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_PSI + 1'b1;

  localparam coeff_set_t NOMINAL_COEFFS = '{
    32'd64880, 32'd7, 32'd65536, 32'd655, 32'd655360, -32'sd589824, 32'd66, 32'd6554
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  dbdq_meas_if meas_if ();
  dbdq_volt_if volt_if ();

  deadbeat_dq_current_controller_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .meas_i     (meas_if),
    .volt_o     (volt_if)
  );

  volt_command_scoreboard sb;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned n_sent;
  int unsigned n_coeff_sets;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          hold_request;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // output side: random stalls, plus the long hold when asked
  initial begin
    volt_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        volt_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        volt_if.ready <= 1'b0;
      end else begin
        volt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // accepted requests and results, plus the watchdog
  always @(posedge clk_i) begin
    if (meas_if.valid && meas_if.ready) begin
      sb.note_request('{meas_if.meas_d_current, meas_if.meas_q_current, meas_if.elec_speed,
                        meas_if.target_d_current, meas_if.target_q_current});
    end
    if (volt_if.valid && volt_if.ready) sb.check_volts(volt_if.volt_d, volt_if.volt_q);
    if ((meas_if.valid && meas_if.ready) || (volt_if.valid && volt_if.ready)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  function automatic word_t rand_word();
    word_t w;
    w = word_t'($urandom());
    case ($urandom_range(7))
      0: ;
      1: begin
        case ($urandom_range(4))
          0:       w = W_MAX;
          1:       w = W_MIN;
          2:       w = '0;
          3:       w = -1;
          default: w = 1;
        endcase
      end
      default: w = w >>> $urandom_range(8, 26);
    endcase
    return w;
  endfunction

  // unsigned registers get a random spare top bit that must be dropped
  function automatic logic [DATA_W-1:0] with_spare_bit(int unsigned v);
    return {1'($urandom_range(1)), UREG_W'(v)};
  endfunction

  function automatic coeff_set_t make_coeffs(coeff_style_e style);
    coeff_set_t c;
    case (style)
      STYLE_TYPICAL: begin
        c.decay     = DATA_W'(FRAC_ONE - $urandom_range(0, 4096));
        c.period    = with_spare_bit($urandom_range(1, 20));
        c.tc_over_l = with_spare_bit($urandom_range(0, 4 * FRAC_ONE));
        c.flux_term = with_spare_bit($urandom_range(0, 4096));
        c.l_over_tc = with_spare_bit($urandom_range(0, 64 * FRAC_ONE));
        c.rmg       = DATA_W'(-int'($urandom_range(0, 64 * FRAC_ONE)));
        c.ind       = with_spare_bit($urandom_range(0, 655));
        c.psi       = with_spare_bit($urandom_range(0, FRAC_ONE));
      end
      STYLE_WIDE: begin
        c = {$urandom(), $urandom(), $urandom(), $urandom(),
             $urandom(), $urandom(), $urandom(), $urandom()};
      end
      STYLE_MAX: begin
        c = '{default: '1};
        c.decay = 32'h7FFF_FFFF;
        c.rmg   = 32'h7FFF_FFFF;
      end
      default: begin
        c = '{default: 32'h8000_0000};
      end
    endcase
    return c;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic drain();
    while (sb.n_results < n_sent) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic apply_coeffs(input coeff_set_t c);
    drain();
    write_reg(REG_DECAY, c.decay);
    write_reg(REG_PERIOD, c.period);
    write_reg(REG_TC_OVER_L, c.tc_over_l);
    write_reg(REG_FLUX_TERM, c.flux_term);
    write_reg(REG_UNUSED_LO + CFG_IDX_W'($urandom_range(0, 7)), $urandom());
    write_reg(REG_L_OVER_TC, c.l_over_tc);
    write_reg(REG_RMG, c.rmg);
    write_reg(REG_IND, c.ind);
    write_reg(REG_PSI, c.psi);
    cfg_we_i <= 1'b0;
    n_coeff_sets++;
  endtask

  task automatic send_request(input meas_req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      meas_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    meas_if.valid            <= 1'b1;
    meas_if.meas_d_current   <= r.id;
    meas_if.meas_q_current   <= r.iq;
    meas_if.elec_speed       <= r.we;
    meas_if.target_d_current <= r.idr;
    meas_if.target_q_current <= r.iqr;
    @(posedge clk_i);
    while (!meas_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic send_list(input meas_req_t list[$]);
    foreach (list[k]) send_request(list[k]);
    meas_if.valid <= 1'b0;
  endtask

  task automatic send_random(input int unsigned count);
    meas_req_t r;
    repeat (count) begin
      r = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
      send_request(r);
    end
    meas_if.valid <= 1'b0;
  endtask

  initial begin
    coeff_style_e seg_style[NUM_SEGS];
    meas_req_t    corner_reqs[$];
    meas_req_t    nominal_reqs[$];
    int unsigned  leftover;

    sb = new(FRAC_BITS_DEF);
    seg_style = '{STYLE_TYPICAL, STYLE_TYPICAL, STYLE_WIDE, STYLE_TYPICAL,
                  STYLE_MAX, STYLE_TYPICAL, STYLE_MIN, STYLE_TYPICAL};
    corner_reqs = '{
      '{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX},
      '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN},
      '{W_MAX, W_MIN, W_MAX, W_MIN, W_MAX},
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}
    };
    nominal_reqs = '{
      '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
      '{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX},
      '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN},
      '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1},
      '{32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1},
      '{W_MAX, W_MIN, W_MAX, W_MIN, W_MAX},
      '{W_MIN, W_MAX, W_MIN, W_MAX, W_MIN},
      '{32'sd327680, -32'sd196608, 32'sd19660800, 32'sd262144, -32'sd131072},
      '{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536},
      '{32'sd0, 32'sd0, W_MAX, 32'sd0, 32'sd0}
    };
    n_sent        = 0;
    n_coeff_sets  = 0;
    quiet_cycles  = 0;
    hold_request  = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 48;

    rst_ni                   <= 1'b0;
    cfg_we_i                 <= 1'b0;
    cfg_idx_i                <= '0;
    cfg_data_i               <= '0;
    meas_if.valid            <= 1'b0;
    meas_if.meas_d_current   <= '0;
    meas_if.meas_q_current   <= '0;
    meas_if.elec_speed       <= '0;
    meas_if.target_d_current <= '0;
    meas_if.target_q_current <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset coefficients first, then nominal and the two extremes
    send_list(corner_reqs[0:1]);
    apply_coeffs(NOMINAL_COEFFS);
    send_list(nominal_reqs);
    apply_coeffs(make_coeffs(STYLE_MAX));
    send_list(corner_reqs);
    apply_coeffs(make_coeffs(STYLE_MIN));
    send_list(corner_reqs);

    for (int s = 0; s < NUM_SEGS; s++) begin
      if (s == 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 15;
      end else if (s == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_coeffs(make_coeffs(seg_style[s]));
      if (s == 1 || s == 6) hold_request = 1'b1;
      send_random(SEG_ITEMS);
    end

    drain();
    leftover = sb.pending();
    $display("covered %0d requests over %0d coefficient sets, %0d results, %0d clamped",
             n_sent, n_coeff_sets, sb.n_results, sb.n_clamped);
    $display("%0d mismatches, %0d expected results never arrived", sb.n_mismatch, leftover);
    if (sb.n_mismatch == 0 && leftover == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
